// ----- rtl/csmr_pkg.sv -----
// Package for the CAN segmented message reassembler.
// Holds store geometry, identifier position codes, the control state type
// and the byte-lane write request shared by the top level and the store.
package csmr_pkg;

  localparam int STORE_BYTES = 256;
  localparam int ROWS        = (STORE_BYTES + 7) / 8;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ASM_W       = $clog2(STORE_BYTES + 1);
  localparam int SUM_W       = ASM_W + 1;
  localparam int LANES       = 8;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    POS_NONE   = 2'd0,
    POS_FIRST  = 2'd1,
    POS_MIDDLE = 2'd2,
    POS_FINAL  = 2'd3
  } pos_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_BOOT = 2'd1,
    S_READ = 2'd2,
    S_LOAD = 2'd3
  } state_t;

  typedef enum logic {
    REG_LOCAL_STATION = 1'b0,
    REG_BOOT_FUNCTION = 1'b1
  } cfg_reg_t;

  // One byte per lane; lane b holds byte addresses with address mod 8 == b.
  typedef struct packed {
    logic [LANES-1:0]            we;
    logic [LANES-1:0][ROW_W-1:0] row;
    logic [LANES-1:0][7:0]       data;
  } store_wr_t;

endpackage

// ----- rtl/can_segmented_message_reassembler.sv -----
// Top level of the CAN segmented message reassembler.
// Depends on csmr_pkg and csmr_store.
//
// Usage: one received extended frame enters per in_ transaction. Frames for
// this station are decoded from the identifier; a boot-function frame gives
// one result with the boot flag in out_tuser. Unsegmented frames and final
// segments deliver the message out of the byte store in 8-byte chunks, with
// out_tlast on the last chunk; first and middle segments give no result.
// Configuration writes on cfg_ are always taken and belong to idle periods.
// Flow: a frame without result frees the input the next cycle. Delivery
// reads one store row per chunk over the memory read port (S_READ issues
// the read, S_LOAD loads the chunk into the output register), and the next
// frame is taken only after the last chunk is loaded. A boot result is
// loaded from S_BOOT. The output register holds a chunk until it is taken
// and a row is fetched only when the slot frees; when the receiver stalls,
// reads stop and the output holds. Reset clears the assembly state and
// loads local_station 0, boot_function 15; the store needs no clearing.
module can_segmented_message_reassembler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [28:0] frame_id, [32:29] byte_count, [96:33] payload, [103:97] zero
  input  logic [csmr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] chunk_data, [67:64] chunk_bytes, [76:68] message_length,
  // [84:77] source_id, [88:85] function_code, [95:89] zero
  output logic [csmr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] boot_request, [1] message_valid
  output logic [csmr_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data
);
  import csmr_pkg::*;

  state_t state_r, state_nxt;
  logic [7:0]       local_station_r;
  logic [3:0]       boot_function_r;
  logic             assembling_r, assembling_nxt;
  logic [6:0]       exp_seq_r, exp_seq_nxt;
  logic [ASM_W-1:0] asm_bytes_r, asm_bytes_nxt;
  logic [ASM_W-1:0] len_r, len_nxt;
  logic [ROW_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       src_r, src_nxt;
  logic [3:0]       func_r, func_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;
  logic                   out_tlast_r, out_tlast_nxt;
  logic                   out_load;

  // Frame decode
  logic [28:0] frame_id;
  logic [3:0]  byte_count;
  logic [63:0] payload;
  logic [7:0]  f_src, f_dst;
  logic [3:0]  f_func;
  logic [6:0]  f_seq;
  pos_t        f_pos;
  logic [3:0]  n_bytes;
  logic        accept, is_local, is_boot, in_order;

  assign frame_id   = in_tdata[28:0];
  assign byte_count = in_tdata[32:29];
  assign payload    = in_tdata[96:33];
  assign f_src      = frame_id[7:0];
  assign f_func     = frame_id[11:8];
  assign f_seq      = frame_id[18:12];
  assign f_pos      = pos_t'(frame_id[20:19]);
  assign f_dst      = frame_id[28:21];
  assign n_bytes    = byte_count[3] ? 4'd8 : byte_count;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign is_local   = (f_dst == local_station_r);
  assign is_boot    = is_local && (f_func == boot_function_r);
  assign in_order   = assembling_r
                   && ({1'b0, f_seq} == ({1'b0, exp_seq_r} + 8'd1))
                   && ((SUM_W'(asm_bytes_r) + SUM_W'(n_bytes)) <= SUM_W'(STORE_BYTES));

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_station_r <= 8'd0;
      boot_function_r <= 4'hF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOCAL_STATION: local_station_r <= cfg_data;
        REG_BOOT_FUNCTION: boot_function_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Store write: base offset and whether this frame writes at all
  logic [ASM_W-1:0] wr_base;
  logic             wr_go;
  store_wr_t        st_wr;
  logic             rd_en;
  logic [63:0]      rd_data;

  always_comb begin
    wr_base = '0;
    wr_go   = 1'b0;
    if (accept && is_local && !is_boot) begin
      case (f_pos)
        POS_NONE, POS_FIRST: wr_go = 1'b1;
        POS_MIDDLE, POS_FINAL: begin
          wr_go   = in_order;
          wr_base = asm_bytes_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [2:0]       off;
    logic [SUM_W-1:0] addr;
    st_wr = '0;
    for (int b = 0; b < LANES; b++) begin
      off  = 3'(b) - wr_base[2:0];
      addr = SUM_W'(wr_base) + SUM_W'(off);
      st_wr.we[b]   = wr_go && ({1'b0, off} < n_bytes) && (addr < SUM_W'(STORE_BYTES));
      st_wr.row[b]  = addr[ROW_W+2:3];
      st_wr.data[b] = payload[8*off +: 8];
    end
  end

  csmr_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_en   (rd_en),
    .rd_row  (cnt_r),
    .rd_data (rd_data)
  );

  // Chunk sizing from the current row
  logic [ASM_W-1:0] rem;
  logic [3:0]       chunk_bytes;
  logic             chunk_last;
  logic [63:0]      chunk_data;

  assign rem         = len_r - ASM_W'({cnt_r, 3'b000});
  assign chunk_last  = (rem <= ASM_W'(8));
  assign chunk_bytes = chunk_last ? rem[3:0] : 4'd8;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      chunk_data[8*i +: 8] = (4'(i) < chunk_bytes) ? rd_data[8*i +: 8] : 8'd0;
    end
  end

  // Control
  always_comb begin
    state_nxt      = state_r;
    assembling_nxt = assembling_r;
    exp_seq_nxt    = exp_seq_r;
    asm_bytes_nxt  = asm_bytes_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    src_nxt        = src_r;
    func_nxt       = func_r;
    rd_en          = 1'b0;
    out_load       = 1'b0;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;

    case (state_r)
      S_IDLE: begin
        if (accept && is_local) begin
          src_nxt  = f_src;
          func_nxt = f_func;
          cnt_nxt  = '0;
          if (is_boot) begin
            assembling_nxt = 1'b0;
            exp_seq_nxt    = '0;
            asm_bytes_nxt  = '0;
            state_nxt      = S_BOOT;
          end else begin
            case (f_pos)
              POS_NONE: begin
                len_nxt   = ASM_W'(n_bytes);
                state_nxt = S_READ;
              end
              POS_FIRST: begin
                assembling_nxt = 1'b1;
                exp_seq_nxt    = f_seq;
                asm_bytes_nxt  = ASM_W'(n_bytes);
              end
              POS_MIDDLE: begin
                if (in_order) begin
                  exp_seq_nxt   = exp_seq_r + 7'd1;
                  asm_bytes_nxt = asm_bytes_r + ASM_W'(n_bytes);
                end
              end
              POS_FINAL: begin
                if (in_order) begin
                  len_nxt        = asm_bytes_r + ASM_W'(n_bytes);
                  assembling_nxt = 1'b0;
                  exp_seq_nxt    = '0;
                  asm_bytes_nxt  = '0;
                  state_nxt      = S_READ;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_BOOT: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_tdata_nxt = {7'd0, func_r, src_r, 9'd0, 4'd0, 64'd0};
          out_tuser_nxt = 2'b01;
          out_tlast_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_READ: begin
        // fetch only when the output slot is free on the following cycle
        if (!out_valid_r || out_tready) begin
          rd_en     = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        out_load      = 1'b1;
        out_tdata_nxt = {7'd0, func_r, src_r, 9'(len_r), chunk_bytes, chunk_data};
        out_tuser_nxt = 2'b10;
        out_tlast_nxt = chunk_last;
        if (chunk_last) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + ROW_W'(1);
          state_nxt = S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      assembling_r <= 1'b0;
      exp_seq_r    <= '0;
      asm_bytes_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      assembling_r <= assembling_nxt;
      exp_seq_r    <= exp_seq_nxt;
      asm_bytes_r  <= asm_bytes_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    cnt_r       <= cnt_nxt;
    src_r       <= src_nxt;
    func_r      <= func_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ----- rtl/csmr_store.sv -----
// Message byte store: eight byte lanes, one synchronous memory per lane.
// Each lane takes one byte write per cycle at its own row; reads fetch one
// aligned row across all lanes with a registered result. Uses csmr_pkg.
module csmr_store (
  input  logic                      clk,
  input  csmr_pkg::store_wr_t       wr,
  input  logic                      rd_en,
  input  logic [csmr_pkg::ROW_W-1:0] rd_row,
  output logic [63:0]               rd_data
);
  import csmr_pkg::*;

  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [7:0] lane_mem [ROWS];
    logic [7:0] lane_q_r;

    always_ff @(posedge clk) begin
      if (wr.we[b]) begin
        lane_mem[wr.row[b]] <= wr.data[b];
      end
      if (rd_en) begin
        lane_q_r <= lane_mem[rd_row];
      end
    end

    assign rd_data[8*b +: 8] = lane_q_r;
  end

endmodule

// ----- dv/testbench.sv -----
// Testbench for can_segmented_message_reassembler: directed and random CAN frames,
// a scoreboard that predicts every result transaction, random idling on both streams.
// Depends on csmr_pkg and the reassembler RTL.
module testbench;
  import csmr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    bit        boot;
    bit        valid;
    bit [63:0] data;
    bit [3:0]  nbytes;
    bit [8:0]  len;
    bit [7:0]  src;
    bit [3:0]  func;
    bit        last;
  } chunk_t;

  typedef enum {
    FLT_NO_FIRST, FLT_BAD_SEQ, FLT_FOREIGN, FLT_BOOT, FLT_UNSEG, FLT_NONE
  } fault_t;

  // Predicts the result transactions of each accepted frame and checks them in order.
  class reassembly_scoreboard;
    bit [7:0]    station;
    bit [3:0]    boot_func;
    bit          open_msg;
    bit [6:0]    last_seq;
    int unsigned collected;
    bit [7:0]    store [STORE_BYTES];
    chunk_t      awaited[$];
    int          mismatches, checked, boots, messages, longest;

    function new();
      station   = 8'h00;
      boot_func = 4'hF;
      clear_assembly();
    endfunction

    function void clear_assembly();
      open_msg  = 1'b0;
      last_seq  = '0;
      collected = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, bit [7:0] val);
      case (idx)
        REG_LOCAL_STATION: station = val;
        REG_BOOT_FUNCTION: boot_func = val[3:0];
        default: ;
      endcase
    endfunction

    function void put_bytes(int unsigned at, bit [63:0] pl, int unsigned n);
      for (int i = 0; i < n; i++)
        if (at + i < STORE_BYTES) store[at + i] = pl[8*i +: 8];
    endfunction

    function void deliver(int unsigned total, bit [7:0] src, bit [3:0] func);
      int unsigned at;
      int unsigned n;
      chunk_t c;
      at = 0;
      messages++;
      if (total > longest) longest = total;
      do begin
        n = (total - at > 8) ? 8 : total - at;
        c = '0;
        c.valid = 1'b1;
        for (int i = 0; i < n; i++) c.data[8*i +: 8] = store[at + i];
        c.nbytes = 4'(n);
        c.len    = 9'(total);
        c.src    = src;
        c.func   = func;
        at += n;
        c.last   = (at >= total);
        awaited.push_back(c);
      end while (at < total);
    endfunction

    function void note_frame(bit [IN_TDATA_W-1:0] word);
      bit [28:0]   id;
      int unsigned n;
      bit [63:0]   pl;
      bit [6:0]    seq;
      pos_t        pos;
      chunk_t      c;
      int unsigned total;
      id  = word[28:0];
      n   = (word[32:29] > 8) ? 8 : word[32:29];
      pl  = word[96:33];
      seq = id[18:12];
      pos = pos_t'(id[20:19]);
      if (id[11:8] == boot_func && id[28:21] == station) begin
        clear_assembly();
        c = '0;
        c.boot = 1'b1;
        c.src  = id[7:0];
        c.func = id[11:8];
        c.last = 1'b1;
        awaited.push_back(c);
        boots++;
        return;
      end
      if (id[28:21] != station) return;
      case (pos)
        POS_NONE: begin
          put_bytes(0, pl, n);
          deliver(n, id[7:0], id[11:8]);
        end
        POS_FIRST: begin
          put_bytes(0, pl, n);
          open_msg  = 1'b1;
          last_seq  = seq;
          collected = n;
        end
        default: begin
          // no wrap: a previous sequence of 127 never matches
          if (!open_msg || int'(seq) != int'(last_seq) + 1 || collected + n > STORE_BYTES)
            return;
          put_bytes(collected, pl, n);
          if (pos == POS_MIDDLE) begin
            last_seq  = seq;
            collected += n;
          end else begin
            total = collected + n;
            clear_assembly();
            deliver(total, id[7:0], id[11:8]);
          end
        end
      endcase
    endfunction

    function void check_result(bit [OUT_TDATA_W-1:0] word, bit [OUT_TUSER_W-1:0] user,
                               bit last);
      chunk_t got, want;
      got.boot   = user[0];
      got.valid  = user[1];
      got.data   = word[63:0];
      got.nbytes = word[67:64];
      got.len    = word[76:68];
      got.src    = word[84:77];
      got.func   = word[88:85];
      got.last   = last;
      checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: boot=%0b valid=%0b data=%h bytes=%0d len=%0d",
                   $realtime, got.boot, got.valid, got.data, got.nbytes, got.len);
        return;
      end
      want = awaited.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result mismatch", $realtime);
          $display("  expected boot=%0b valid=%0b data=%h bytes=%0d len=%0d src=%h fn=%h last=%0b",
                   want.boot, want.valid, want.data, want.nbytes, want.len, want.src,
                   want.func, want.last);
          $display("  actual   boot=%0b valid=%0b data=%h bytes=%0d len=%0d src=%h fn=%h last=%0b",
                   got.boot, got.valid, got.data, got.nbytes, got.len, got.src,
                   got.func, got.last);
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = REG_LOCAL_STATION;
  logic [7:0]             cfg_data = 8'h00;

  reassembly_scoreboard sb = new();

  int       send_idle = 0;
  int       recv_idle = 0;
  int       idle_cycles = 0;
  int       frames_sent = 0;
  int       local_sent = 0;
  bit [7:0] cur_station = 8'h00;
  bit [3:0] cur_boot = 4'hF;

  can_segmented_message_reassembler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_tvalid && in_tready) sb.note_frame(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // Abort when no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic bit [28:0] make_id(bit [7:0] dst, pos_t pos, bit [6:0] seq,
                                        bit [3:0] func, bit [7:0] src);
    return {dst, pos, seq, func, src};
  endfunction

  function automatic bit [3:0] pick_func();
    bit [3:0] f;
    do f = 4'($urandom_range(0, 15)); while (f == cur_boot);
    return f;
  endfunction

  // Mostly legal counts, some oversized ones.
  function automatic bit [3:0] rand_count();
    return ($urandom_range(0, 99) < 15) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
  endfunction

  function automatic bit [63:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // Enter and leave at a falling edge; valid stays high after the transaction.
  task automatic send_frame(bit [28:0] id, bit [3:0] cnt, bit [63:0] pl);
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_tdata  <= {7'b0, pl, cnt, id};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    frames_sent++;
    if (id[28:21] == cur_station) local_sent++;
    @(negedge clk);
  endtask

  task automatic write_config(bit [7:0] station, bit [3:0] boot_fn);
    cfg_valid <= 1'b1;
    cfg_index <= REG_LOCAL_STATION;
    cfg_data  <= station;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_BOOT_FUNCTION;
    cfg_data  <= {4'($urandom_range(0, 15)), boot_fn};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    cur_station  = station;
    cur_boot     = boot_fn;
  endtask

  // Drop valid, drain every awaited result, then give the block time to settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_directed();
    bit [7:0] foreign;
    foreign = ~cur_station;
    send_frame(make_id(cur_station, POS_NONE, 7'd0, 4'h1, 8'h11), 4'd0, rand_payload());
    send_frame(make_id(cur_station, POS_NONE, 7'h7F, 4'hF, 8'hFF), 4'd8, '1);
    send_frame(make_id(cur_station, POS_NONE, 7'd0, 4'h0, 8'h00), 4'd15, rand_payload());
    send_frame(make_id(foreign, POS_NONE, 7'd3, 4'h2, 8'h22), 4'd8, rand_payload());
    send_frame(make_id(cur_station, POS_FIRST, 7'd9, cur_boot, 8'h33), 4'd4, rand_payload());
    send_frame(make_id(foreign, POS_NONE, 7'd0, cur_boot, 8'h44), 4'd2, rand_payload());
    // continuation segments with nothing open
    send_frame(make_id(cur_station, POS_MIDDLE, 7'd1, 4'h2, 8'h55), 4'd8, rand_payload());
    send_frame(make_id(cur_station, POS_FINAL, 7'd1, 4'h2, 8'h55), 4'd8, rand_payload());
    // out-of-order middle dropped; unsegmented frame overwrites the store head
    send_frame(make_id(cur_station, POS_FIRST, 7'd5, 4'h6, 8'h66), 4'd8, rand_payload());
    send_frame(make_id(cur_station, POS_MIDDLE, 7'd6, 4'h6, 8'h66), 4'd12, rand_payload());
    send_frame(make_id(cur_station, POS_MIDDLE, 7'd8, 4'h6, 8'h66), 4'd8, rand_payload());
    send_frame(make_id(cur_station, POS_NONE, 7'd0, 4'h7, 8'h77), 4'd3, rand_payload());
    send_frame(make_id(cur_station, POS_FINAL, 7'd7, 4'h6, 8'h66), 4'd5, rand_payload());
    // sequence 127 has no successor
    send_frame(make_id(cur_station, POS_FIRST, 7'h7F, 4'h8, 8'h88), 4'd2, rand_payload());
    send_frame(make_id(cur_station, POS_MIDDLE, 7'd0, 4'h8, 8'h88), 4'd2, rand_payload());
    send_frame(make_id(cur_station, POS_FINAL, 7'd0, 4'h8, 8'h88), 4'd2, rand_payload());
    // boot frame abandons the open message
    send_frame(make_id(cur_station, POS_FIRST, 7'd20, 4'h9, 8'h99), 4'd4, rand_payload());
    send_frame(make_id(cur_station, POS_MIDDLE, 7'd21, cur_boot, 8'hAA), 4'd8, rand_payload());
    send_frame(make_id(cur_station, POS_FINAL, 7'd21, 4'h9, 8'h99), 4'd4, rand_payload());
    // empty segmented message
    send_frame(make_id(cur_station, POS_FIRST, 7'd30, 4'hA, 8'hBB), 4'd0, rand_payload());
    send_frame(make_id(cur_station, POS_FINAL, 7'd31, 4'hA, 8'hBB), 4'd0, rand_payload());
    // a second first segment restarts the assembly
    send_frame(make_id(cur_station, POS_FIRST, 7'd40, 4'hB, 8'hCC), 4'd8, rand_payload());
    send_frame(make_id(cur_station, POS_FIRST, 7'd50, 4'hB, 8'hCC), 4'd3, rand_payload());
    send_frame(make_id(cur_station, POS_FINAL, 7'd51, 4'hB, 8'hCC), 4'd2, rand_payload());
  endtask

  // Fill the store to capacity, try to pass it, then close with an empty final.
  task automatic send_full_store();
    bit [6:0] seq;
    bit [7:0] src;
    bit [3:0] func;
    seq  = 7'($urandom_range(0, 90));
    src  = 8'($urandom);
    func = pick_func();
    send_frame(make_id(cur_station, POS_FIRST, seq, func, src), 4'd8, rand_payload());
    repeat (STORE_BYTES / 8 - 1) begin
      seq++;
      send_frame(make_id(cur_station, POS_MIDDLE, seq, func, src), 4'd8, rand_payload());
    end
    send_frame(make_id(cur_station, POS_MIDDLE, seq + 7'd1, func, src), 4'd1, rand_payload());
    send_frame(make_id(cur_station, POS_FINAL, seq + 7'd1, func, src), 4'd9, rand_payload());
    send_frame(make_id(cur_station, POS_FINAL, seq + 7'd1, func, src), 4'd0, rand_payload());
  endtask

  task automatic send_message();
    bit [6:0] seq;
    bit [7:0] src;
    bit [3:0] func;
    int       nmid;
    int       bad_at;
    fault_t   fault;
    seq    = 7'($urandom_range(0, 127));
    src    = 8'($urandom);
    func   = pick_func();
    nmid   = $urandom_range(0, 5);
    bad_at = $urandom_range(0, nmid);
    fault  = ($urandom_range(0, 14) > 4) ? FLT_NONE : fault_t'($urandom_range(0, 4));
    if (fault != FLT_NO_FIRST)
      send_frame(make_id(cur_station, POS_FIRST, seq, func, src), rand_count(), rand_payload());
    for (int i = 0; i <= nmid; i++) begin
      if (i == bad_at) begin
        case (fault)
          FLT_BAD_SEQ:
            send_frame(make_id(cur_station, POS_MIDDLE, seq + 7'd2, func, src), rand_count(),
                       rand_payload());
          FLT_FOREIGN:
            send_frame(make_id(~cur_station, POS_MIDDLE, seq + 7'd1, func, src), rand_count(),
                       rand_payload());
          FLT_BOOT:
            send_frame(make_id(cur_station, POS_MIDDLE, seq + 7'd1, cur_boot, src),
                       rand_count(), rand_payload());
          FLT_UNSEG:
            send_frame(make_id(cur_station, POS_NONE, 7'($urandom), pick_func(),
                               8'($urandom)), rand_count(), rand_payload());
          default: ;
        endcase
      end
      seq++;
      send_frame(make_id(cur_station, (i == nmid) ? POS_FINAL : POS_MIDDLE, seq, func, src),
                 rand_count(), rand_payload());
    end
  endtask

  task automatic send_random(int goal);
    int sel;
    goal += local_sent;
    while (local_sent < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 50)
        send_message();
      else if (sel < 70)
        send_frame(make_id(cur_station, POS_NONE, 7'($urandom), pick_func(), 8'($urandom)),
                   rand_count(), rand_payload());
      else if (sel < 78)
        send_frame(make_id(cur_station, pos_t'($urandom_range(0, 3)), 7'($urandom), cur_boot,
                           8'($urandom)), rand_count(), rand_payload());
      else if (sel < 90)
        send_frame(make_id(cur_station, pos_t'($urandom_range(0, 3)), 7'($urandom),
                           4'($urandom), 8'($urandom)), rand_count(), rand_payload());
      else
        send_frame(29'($urandom), 4'($urandom), rand_payload());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 20;
    recv_idle = 81;
    write_config(8'hA5, 4'h3);
    send_directed();
    send_random(20);
    drain();

    send_idle = 81;
    recv_idle = 20;
    write_config(8'h00, 4'h0);
    send_random(20);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_config(8'hFF, 4'hF);
    send_full_store();
    send_random(15);
    drain();

    $display("%0d frames sent, %0d addressed here, over three station/boot settings",
             frames_sent, local_sent);
    $display("%0d results checked: %0d messages (longest %0d bytes), %0d boot requests",
             sb.checked, sb.messages, sb.longest, sb.boots);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results still awaited", sb.mismatches, sb.pending());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/csmr_pkg.sv
rtl/csmr_store.sv
rtl/can_segmented_message_reassembler.sv
dv/testbench.sv
